// ----- hdl/two_level_feedback_scheduler_assert.svh -----
// Assertion macros shared by the scheduler RTL.
// Each macro expects clk and rst to be visible at the point of use.
`ifndef TWO_LEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH
`define TWO_LEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TLFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/tlfs_pkg.sv -----
// ----------------------------------------------------------------------------
// tlfs_pkg
// Shared types, codes and constants of the two-level feedback scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tlfs_pkg;

  localparam int unsigned TLFS_NUM_THREADS = 16;
  localparam int unsigned ID_W             = 4;
  localparam int unsigned TIME_W           = 16;

  localparam logic [TIME_W-1:0] FIRST_QUANTUM_RST  = 16'd40;
  localparam logic [TIME_W-1:0] SECOND_QUANTUM_RST = 16'd60;
  localparam logic [TIME_W-1:0] TICK_INTERVAL_RST  = 16'd20;

  // Event codes.
  localparam logic [2:0] MODE_TICK     = 3'd0;
  localparam logic [2:0] MODE_ADD      = 3'd1;
  localparam logic [2:0] MODE_FINISHED = 3'd2;
  localparam logic [2:0] MODE_BLOCKED  = 3'd3;
  localparam logic [2:0] MODE_WAKE_ONE = 3'd4;
  localparam logic [2:0] MODE_WAKE_ALL = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_FIRST_QUANTUM  = 2'd0;
  localparam logic [1:0] REG_SECOND_QUANTUM = 2'd1;
  localparam logic [1:0] REG_TICK_INTERVAL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DISPATCH,
    ST_WAKE,
    ST_DONE
  } state_t;

  // Controls for one cell of a queue chain.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  // Request to one queue.
  typedef struct packed {
    logic            push;
    logic            pop;
    logic [ID_W-1:0] push_id;
  } fifo_ctl_t;

  // Thread id reduced modulo the thread count by repeated subtraction.
  function automatic logic [ID_W-1:0] id_slot(input logic [ID_W-1:0] id,
                                              input int unsigned n);
    logic [8:0] v;
    logic [8:0] m;
    v = {5'd0, id};
    m = 9'(n);
    for (int k = 0; k < 8; k++) begin
      if (v >= m) begin
        v = v - m;
      end
    end
    return v[ID_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/tlfs_cell.sv -----
// ----------------------------------------------------------------------------
// tlfs_cell
// One entry of a queue chain: loads a new id or takes its neighbor's id.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfs_cell (
  input  wire logic                  clk,
  input  wire tlfs_pkg::cell_ctl_t   ctl,
  input  wire logic [tlfs_pkg::ID_W-1:0] load_id,
  input  wire logic [tlfs_pkg::ID_W-1:0] shift_id,
  output logic [tlfs_pkg::ID_W-1:0]      val
);
  import tlfs_pkg::*;

  // A load wins over the shift from the neighbor.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val <= load_id;
    end else if (ctl.shift) begin
      val <= shift_id;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tlfs_fifo.sv -----
// ----------------------------------------------------------------------------
// tlfs_fifo
// Id queue built as a chain of cells; the head sits in cell zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfs_fifo #(
  parameter int unsigned NUM_THREADS = tlfs_pkg::TLFS_NUM_THREADS,
  localparam int unsigned CNT_W = $clog2(NUM_THREADS + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tlfs_pkg::fifo_ctl_t        ctl,
  output logic [tlfs_pkg::ID_W-1:0]       head,
  output logic [CNT_W-1:0]                count
);
  import tlfs_pkg::*;

  logic [ID_W-1:0]  vals [NUM_THREADS];
  logic             push_ok;
  logic [CNT_W-1:0] load_pos;

  // A push into a full queue is dropped.
  assign push_ok  = ctl.push && (count != CNT_W'(NUM_THREADS));
  assign load_pos = ctl.pop ? (count - CNT_W'(1)) : count;
  assign head     = vals[0];

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + CNT_W'(push_ok) - CNT_W'(ctl.pop);
    end
  end

  // Chain of cells shifting toward the head on a pop.
  for (genvar i = 0; i < NUM_THREADS; i++) begin : g_cell
    cell_ctl_t       cctl;
    logic [ID_W-1:0] nb;
    assign cctl.shift = ctl.pop;
    assign cctl.load  = push_ok && (load_pos == CNT_W'(i));
    if (i == NUM_THREADS - 1) begin : g_last
      assign nb = '0;
    end else begin : g_mid
      assign nb = vals[i+1];
    end
    tlfs_cell u_cell (
      .clk      (clk),
      .ctl      (cctl),
      .load_id  (ctl.push_id),
      .shift_id (nb),
      .val      (vals[i])
    );
  end

endmodule

`default_nettype wire

// ----- hdl/two_level_feedback_scheduler.sv -----
// ----------------------------------------------------------------------------
// two_level_feedback_scheduler
// Two-level feedback thread scheduler with level-one, level-two and blocked
// queues kept as chains of cells.
// ----------------------------------------------------------------------------
// Usage: an event (mode, thread_id) is taken on a clock edge where start is
// high and busy is low. When the event is handled, done is high for exactly
// one cycle and running_id, is_idle and the three queue counts show the state
// after the event; the receiver cannot stall and must take it then.
// The event is handled in EXEC and done is shown in DONE; a tick that demotes
// the running thread passes through DISPATCH between them, since the push
// into level two and the following dispatch use separate cycles. Wake all
// pops one blocked thread per cycle, first in EXEC and then in WAKE, until
// the blocked queue is empty. A new event may be accepted in the done cycle.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at the
// next edge. They must be made only while no event is in progress; the block
// itself does not enforce this.
// Synchronous reset empties all queues, makes the scheduler idle and loads
// the default quanta and tick interval. Per-thread time entries hold no
// value until the thread is first added.
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_level_feedback_scheduler_assert.svh"

module two_level_feedback_scheduler #(
  parameter int unsigned NUM_THREADS = tlfs_pkg::TLFS_NUM_THREADS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  output logic                              done,
  input  wire logic [2:0]                   mode,
  input  wire logic [tlfs_pkg::ID_W-1:0]    thread_id,
  input  wire logic                         cfg_wr_en,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [tlfs_pkg::TIME_W-1:0]  cfg_data,
  output logic [tlfs_pkg::ID_W-1:0]         running_id,
  output logic                              is_idle,
  output logic [4:0]                        first_count,
  output logic [4:0]                        second_count,
  output logic [4:0]                        blocked_count
);
  import tlfs_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_THREADS + 1);
  localparam int unsigned AW    = $clog2(NUM_THREADS);

  state_t state, state_next;

  logic [2:0]        mode_q;
  logic [ID_W-1:0]   id_q;
  logic [ID_W-1:0]   running, running_next;
  logic              idle_flag, idle_next;
  logic [TIME_W-1:0] first_q, second_q, tick_ival;

  fifo_ctl_t         f1_ctl, f2_ctl, bl_ctl;
  logic [ID_W-1:0]   f1_head, f2_head, bl_head;
  logic [CNT_W-1:0]  f1_cnt, f2_cnt, bl_cnt;

  logic [2*TIME_W-1:0] mem [NUM_THREADS];
  logic [2*TIME_W-1:0] rd_word;
  logic [2*TIME_W-1:0] wr_word;
  logic [AW-1:0]       wr_addr;
  logic                wr_en;
  logic [AW-1:0]       rd_addr;

  logic [TIME_W-1:0] rd_used, rd_limit;
  logic [TIME_W:0]   sum;
  logic              first_ne, second_ne, blk_ne;
  logic              tick_preempt, tick_keep, tick_demote;
  logic              do_dispatch;

  assign first_ne  = (f1_cnt != '0);
  assign second_ne = (f2_cnt != '0);
  assign blk_ne    = (bl_cnt != '0);

  assign rd_limit     = rd_word[2*TIME_W-1:TIME_W];
  assign rd_used      = rd_word[TIME_W-1:0];
  assign sum          = {1'b0, rd_used} + {1'b0, tick_ival};
  assign tick_preempt = (rd_limit == second_q) && first_ne;
  assign tick_keep    = sum < {1'b0, rd_limit};
  assign tick_demote  = !idle_flag && !tick_preempt && !tick_keep;

  // Per-thread time table: {limit, used}, read at the running thread's slot.
  assign rd_addr = AW'(id_slot(running, NUM_THREADS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    rd_word <= mem[rd_addr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_q   <= FIRST_QUANTUM_RST;
      second_q  <= SECOND_QUANTUM_RST;
      tick_ival <= TICK_INTERVAL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FIRST_QUANTUM:  first_q   <= cfg_data;
        REG_SECOND_QUANTUM: second_q  <= cfg_data;
        REG_TICK_INTERVAL:  tick_ival <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state) inside
      ST_IDLE, ST_DONE: begin
        state_next = start ? ST_EXEC : ST_IDLE;
      end
      ST_EXEC: begin
        state_next = ST_DONE;
        if (mode_q == MODE_TICK && tick_demote) begin
          state_next = ST_DISPATCH;
        end else if (mode_q == MODE_WAKE_ALL && bl_cnt > CNT_W'(1)) begin
          state_next = ST_WAKE;
        end
      end
      ST_WAKE: begin
        state_next = (bl_cnt > CNT_W'(1)) ? ST_WAKE : ST_DONE;
      end
      ST_DISPATCH: begin
        state_next = ST_DONE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      ST_IDLE: busy = 1'b0;
      ST_DONE: begin
        busy = 1'b0;
        done = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  // Event datapath: queue requests, table writes and the running thread.
  always_comb begin
    f1_ctl       = '0;
    f2_ctl       = '0;
    bl_ctl       = '0;
    wr_en        = 1'b0;
    wr_addr      = AW'(id_slot(id_q, NUM_THREADS));
    wr_word      = {first_q, {TIME_W{1'b0}}};
    running_next = running;
    idle_next    = idle_flag;
    do_dispatch  = 1'b0;

    if (state == ST_EXEC) begin
      case (mode_q) inside
        MODE_TICK: begin
          if (idle_flag) begin
            do_dispatch = 1'b1;
          end else begin
            wr_en   = 1'b1;
            wr_addr = rd_addr;
            if (tick_preempt) begin
              wr_word        = {rd_limit, {TIME_W{1'b0}}};
              f2_ctl.push    = 1'b1;
              f2_ctl.push_id = running;
              f1_ctl.pop     = 1'b1;
              running_next   = f1_head;
            end else if (tick_keep) begin
              wr_word = {rd_limit, sum[TIME_W-1:0]};
            end else begin
              wr_word        = {second_q, {TIME_W{1'b0}}};
              f2_ctl.push    = 1'b1;
              f2_ctl.push_id = running;
            end
          end
        end
        MODE_ADD: begin
          wr_en          = 1'b1;
          f1_ctl.push    = 1'b1;
          f1_ctl.push_id = id_q;
        end
        MODE_FINISHED: begin
          do_dispatch = 1'b1;
        end
        MODE_BLOCKED: begin
          if (!idle_flag) begin
            bl_ctl.push    = 1'b1;
            bl_ctl.push_id = running;
            do_dispatch    = 1'b1;
          end
        end
        MODE_WAKE_ONE, MODE_WAKE_ALL: begin
          if (blk_ne) begin
            bl_ctl.pop     = 1'b1;
            wr_en          = 1'b1;
            wr_addr        = AW'(id_slot(bl_head, NUM_THREADS));
            f1_ctl.push    = 1'b1;
            f1_ctl.push_id = bl_head;
          end
        end
        default: ;
      endcase
    end else if (state == ST_WAKE) begin
      bl_ctl.pop     = 1'b1;
      wr_en          = 1'b1;
      wr_addr        = AW'(id_slot(bl_head, NUM_THREADS));
      f1_ctl.push    = 1'b1;
      f1_ctl.push_id = bl_head;
    end else if (state == ST_DISPATCH) begin
      do_dispatch = 1'b1;
    end

    // Dispatch: level one first, then level two, else the idle marker.
    if (do_dispatch) begin
      if (first_ne) begin
        f1_ctl.pop   = 1'b1;
        running_next = f1_head;
        idle_next    = 1'b0;
      end else if (second_ne) begin
        f2_ctl.pop   = 1'b1;
        running_next = f2_head;
        idle_next    = 1'b0;
      end else begin
        running_next = '0;
        idle_next    = 1'b1;
      end
    end else if (state == ST_EXEC && mode_q == MODE_TICK && tick_preempt
                 && !idle_flag) begin
      idle_next = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      running   <= '0;
      idle_flag <= 1'b1;
    end else begin
      state     <= state_next;
      running   <= running_next;
      idle_flag <= idle_next;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      mode_q <= mode;
      id_q   <= thread_id;
    end
  end

  tlfs_fifo #(.NUM_THREADS(NUM_THREADS)) u_first (
    .clk   (clk),
    .rst   (rst),
    .ctl   (f1_ctl),
    .head  (f1_head),
    .count (f1_cnt)
  );

  tlfs_fifo #(.NUM_THREADS(NUM_THREADS)) u_second (
    .clk   (clk),
    .rst   (rst),
    .ctl   (f2_ctl),
    .head  (f2_head),
    .count (f2_cnt)
  );

  tlfs_fifo #(.NUM_THREADS(NUM_THREADS)) u_blocked (
    .clk   (clk),
    .rst   (rst),
    .ctl   (bl_ctl),
    .head  (bl_head),
    .count (bl_cnt)
  );

  // Result ports.
  assign running_id    = running;
  assign is_idle       = idle_flag;
  assign first_count   = 5'(f1_cnt);
  assign second_count  = 5'(f2_cnt);
  assign blocked_count = 5'(bl_cnt);

  // Checks.
  `TLFS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not start")
  `TLFS_ASSERT_NOW(a_idle_id, is_idle, running_id == '0, "idle with nonzero running id")
  `TLFS_ASSERT_NEXT(a_done_once, done, !done, "result strobe held two cycles")
  `TLFS_ASSERT_NOW(a_wake_all, done && mode_q == MODE_WAKE_ALL, blocked_count == 5'd0, "wake all left blocked threads")

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-level feedback scheduler. Event requests
// are queued, then driven with random gaps. A behavioral copy of the
// scheduler predicts the state that each done strobe reports, and the
// monitor compares every field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import tlfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]      mode;
    logic [ID_W-1:0] thread_id;
    logic            is_cfg;
    logic [1:0]      cfg_index;
    logic [TIME_W-1:0] cfg_data;
    logic            drain;
  } request_t;

  typedef struct packed {
    logic [ID_W-1:0] running_id;
    logic            is_idle;
    logic [4:0]      first_count;
    logic [4:0]      second_count;
    logic [4:0]      blocked_count;
  } sched_view_t;

  localparam int unsigned DEPTH = TLFS_NUM_THREADS;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  logic [2:0] mode;
  logic [ID_W-1:0] thread_id;
  logic cfg_wr_en;
  logic [1:0] cfg_index;
  logic [TIME_W-1:0] cfg_data;
  logic [ID_W-1:0] running_id;
  logic is_idle;
  logic [4:0] first_count;
  logic [4:0] second_count;
  logic [4:0] blocked_count;
  logic busy_at_edge;

  two_level_feedback_scheduler i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .mode(mode), .thread_id(thread_id), .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .running_id(running_id),
    .is_idle(is_idle), .first_count(first_count), .second_count(second_count),
    .blocked_count(blocked_count)
  );

  // Predictor state.
  logic [ID_W-1:0] lvl1_q[$];
  logic [ID_W-1:0] lvl2_q[$];
  logic [ID_W-1:0] wait_q[$];
  logic [ID_W-1:0] cur_thread = '0;
  logic cur_idle = 1'b1;
  logic [TIME_W-1:0] thread_used[DEPTH];
  logic [TIME_W-1:0] thread_limit[DEPTH];
  logic [TIME_W-1:0] quantum1 = FIRST_QUANTUM_RST;
  logic [TIME_W-1:0] quantum2 = SECOND_QUANTUM_RST;
  logic [TIME_W-1:0] interval = TICK_INTERVAL_RST;

  request_t pending_reqs[$];
  sched_view_t expected_views[$];
  int unsigned mismatch_count;
  int unsigned checked_count;
  int unsigned cycle_count;
  int unsigned gap_left;
  int unsigned tick_count;
  int unsigned wake_all_count;
  bit stim_done;

  // Bounded push: a full queue drops the id.
  function automatic void push_id(ref logic [ID_W-1:0] q[$], input logic [ID_W-1:0] id);
    if (q.size() < DEPTH) begin
      q.insert(q.size(), id);
    end
  endfunction

  // Removes and returns the oldest id of a queue.
  function automatic logic [ID_W-1:0] take_id(ref logic [ID_W-1:0] q[$]);
    logic [ID_W-1:0] id;
    id = q[0];
    q.delete(0);
    return id;
  endfunction

  function automatic void add_req(input request_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic void enter_level1(input logic [ID_W-1:0] id);
    thread_used[id] = '0;
    thread_limit[id] = quantum1;
    push_id(lvl1_q, id);
  endfunction

  function automatic void pick_next();
    if (lvl1_q.size() != 0) begin
      cur_thread = take_id(lvl1_q);
      cur_idle = 1'b0;
    end else if (lvl2_q.size() != 0) begin
      cur_thread = take_id(lvl2_q);
      cur_idle = 1'b0;
    end else begin
      cur_thread = '0;
      cur_idle = 1'b1;
    end
  endfunction

  function automatic void run_tick();
    logic [16:0] sum;
    if (cur_idle) begin
      pick_next();
    end else if (thread_limit[cur_thread] == quantum2 && lvl1_q.size() != 0) begin
      // A level-two thread yields to waiting level-one work.
      thread_used[cur_thread] = '0;
      push_id(lvl2_q, cur_thread);
      cur_thread = take_id(lvl1_q);
    end else begin
      sum = {1'b0, thread_used[cur_thread]} + {1'b0, interval};
      if (sum < {1'b0, thread_limit[cur_thread]}) begin
        thread_used[cur_thread] = sum[TIME_W-1:0];
      end else begin
        // Quantum used up: demote to level two.
        thread_used[cur_thread] = '0;
        thread_limit[cur_thread] = quantum2;
        push_id(lvl2_q, cur_thread);
        pick_next();
      end
    end
  endfunction

  // Applies one event and returns the reported state.
  function automatic sched_view_t predict_event(input request_t r);
    sched_view_t v;
    case (r.mode)
      MODE_TICK: run_tick();
      MODE_ADD: enter_level1(r.thread_id);
      MODE_FINISHED: pick_next();
      MODE_BLOCKED: begin
        if (!cur_idle) begin
          push_id(wait_q, cur_thread);
          pick_next();
        end
      end
      MODE_WAKE_ONE: begin
        if (wait_q.size() != 0) begin
          enter_level1(take_id(wait_q));
        end
      end
      MODE_WAKE_ALL: begin
        while (wait_q.size() != 0) begin
          enter_level1(take_id(wait_q));
        end
      end
      default: ;
    endcase
    v.running_id = cur_idle ? '0 : cur_thread;
    v.is_idle = cur_idle;
    v.first_count = 5'(lvl1_q.size());
    v.second_count = 5'(lvl2_q.size());
    v.blocked_count = 5'(wait_q.size());
    return v;
  endfunction

  function automatic request_t make_event(input logic [2:0] m, input logic [ID_W-1:0] id);
    request_t r;
    r = '0;
    r.mode = m;
    r.thread_id = id;
    return r;
  endfunction

  function automatic request_t make_write(input logic [1:0] idx, input logic [TIME_W-1:0] d);
    request_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cfg_index = idx;
    r.cfg_data = d;
    return r;
  endfunction

  function automatic request_t make_drain();
    request_t r;
    r = '0;
    r.drain = 1'b1;
    return r;
  endfunction

  // Random event, weighted toward ticks and adds so the queues fill.
  function automatic request_t random_event();
    int unsigned w;
    logic [2:0] m;
    w = $urandom_range(0, 99);
    if (w < 35) m = MODE_TICK;
    else if (w < 60) m = MODE_ADD;
    else if (w < 70) m = MODE_FINISHED;
    else if (w < 82) m = MODE_BLOCKED;
    else if (w < 90) m = MODE_WAKE_ONE;
    else if (w < 96) m = MODE_WAKE_ALL;
    else m = 3'($urandom_range(6, 7));
    return make_event(m, ID_W'($urandom));
  endfunction

  task automatic queue_config(input logic [TIME_W-1:0] q1, input logic [TIME_W-1:0] q2,
                              input logic [TIME_W-1:0] ti);
    add_req(make_drain());
    add_req(make_write(REG_FIRST_QUANTUM, q1));
    add_req(make_write(REG_SECOND_QUANTUM, q2));
    add_req(make_write(REG_TICK_INTERVAL, ti));
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stimulus list.
  initial begin
    // Directed: idle corner cases, then every event kind.
    add_req(make_event(MODE_TICK, '0));
    add_req(make_event(MODE_BLOCKED, '0));
    add_req(make_event(MODE_WAKE_ONE, '0));
    add_req(make_event(MODE_WAKE_ALL, '0));
    add_req(make_event(MODE_FINISHED, '0));
    add_req(make_event(3'd6, 4'hF));
    add_req(make_event(3'd7, 4'h0));
    add_req(make_event(MODE_ADD, 4'h0));
    add_req(make_event(MODE_ADD, 4'hF));
    add_req(make_event(MODE_ADD, 4'h5));
    for (int i = 0; i < 4; i++) add_req(make_event(MODE_TICK, '0));
    add_req(make_event(MODE_BLOCKED, '0));
    add_req(make_event(MODE_BLOCKED, '0));
    add_req(make_event(MODE_WAKE_ONE, '0));
    add_req(make_event(MODE_WAKE_ALL, '0));
    add_req(make_event(MODE_FINISHED, '0));
    // Overfill level one so pushes get dropped, including duplicate ids.
    for (int i = 0; i < 18; i++) add_req(make_event(MODE_ADD, ID_W'(i)));
    for (int i = 0; i < 6; i++) add_req(make_event(MODE_TICK, '0));

    // Random phases over several register settings, extremes among them.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: queue_config(16'd40, 16'd60, 16'd20);
        1: queue_config(16'd0, 16'd0, 16'd0);
        2: queue_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: queue_config(16'd30, 16'd30, 16'd10);
        4: queue_config(16'hFFFF, 16'd1, 16'h8000);
        5: queue_config(16'd1, 16'hFFFF, 16'd1);
        default: queue_config(16'($urandom_range(0, 120)), 16'($urandom_range(0, 120)),
                              16'($urandom_range(0, 50)));
      endcase
      for (int i = 0; i < 140; i++) add_req(random_event());
    end
    // Full-range values to toggle every register bit.
    queue_config(16'($urandom), 16'($urandom), 16'($urandom));
    for (int i = 0; i < 50; i++) add_req(random_event());
  end

  // Driver: one request per handshake, random gap before each.
  always @(negedge clk) begin
    request_t r;
    if (rst) begin
      start <= 1'b0;
      cfg_wr_en <= 1'b0;
      mode <= MODE_TICK;
      thread_id <= '0;
      cfg_index <= REG_FIRST_QUANTUM;
      cfg_data <= '0;
      gap_left <= $urandom_range(0, 19);
    end else if (start && !busy_at_edge) begin
      // Previous request was taken at the last edge.
      start <= 1'b0;
      gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    end else if (start) begin
      // Hold the request until accepted.
    end else if (cfg_wr_en) begin
      cfg_wr_en <= 1'b0;
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
    end else if (pending_reqs.size() != 0) begin
      r = pending_reqs[0];
      if (r.drain) begin
        // Let the block settle completely before touching registers.
        if (expected_views.size() == 0 && !busy) begin
          pending_reqs.delete(0);
        end
      end else if (r.is_cfg) begin
        pending_reqs.delete(0);
        cfg_wr_en <= 1'b1;
        cfg_index <= r.cfg_index;
        cfg_data <= r.cfg_data;
        case (r.cfg_index)
          REG_FIRST_QUANTUM: quantum1 = r.cfg_data;
          REG_SECOND_QUANTUM: quantum2 = r.cfg_data;
          default: interval = r.cfg_data;
        endcase
      end else begin
        pending_reqs.delete(0);
        start <= 1'b1;
        mode <= r.mode;
        thread_id <= r.thread_id;
        if (r.mode == MODE_TICK) tick_count++;
        if (r.mode == MODE_WAKE_ALL) wake_all_count++;
      end
    end else begin
      stim_done <= 1'b1;
    end
  end

  // Acceptance is sampled at the rising edge; the prediction is made then.
  always @(posedge clk) begin
    if (rst) begin
      busy_at_edge <= 1'b1;
    end else begin
      busy_at_edge <= busy;
      if (start && !busy) begin
        expected_views.insert(expected_views.size(),
                              predict_event(make_event(mode, thread_id)));
      end
    end
  end

  // Monitor: each done strobe is checked against the oldest prediction.
  always @(posedge clk) begin
    sched_view_t got;
    sched_view_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      got = '{running_id, is_idle, first_count, second_count, blocked_count};
      if (expected_views.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result %p", got);
      end else begin
        want = expected_views[0];
        expected_views.delete(0);
        checked_count++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  // Reset, end of run and timeout.
  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    while (!(stim_done && !start && expected_views.size() == 0)
           && cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout with %0d results outstanding", expected_views.size());
      $display("Verification failed");
    end else begin
      repeat (40) @(posedge clk);
      $display("Checked %0d scheduler results (%0d ticks, %0d wake-all events)",
               checked_count, tick_count, wake_all_count);
      $display("over several quantum and tick settings; %0d mismatches.", mismatch_count);
      if (mismatch_count == 0 && expected_views.size() == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
    end
    $finish;
  end

endmodule

`default_nettype wire
